>>> design/gnfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gnfc_pkg
// Shared types and constants of the grid node friction collision pipeline.
// ============================================================================
package gnfc_pkg;

   // contact classification codes
   localparam logic [1:0] KIND_PASS  = 2'd0;
   localparam logic [1:0] KIND_STUCK = 2'd1;
   localparam logic [1:0] KIND_SLIDE = 2'd2;

   // one stage per result bit in the square root and the divider
   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = 32;

   // data that rides beside the square root unit
   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] tan_x;
      logic signed [31:0] tan_y;
      logic signed [31:0] tan_z;
      logic        [40:0] thr;
      logic               contact;
   } sq_side_type;

   // data that rides beside the dividers
   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic               contact;
      logic               stuck;
      logic               nzero;
      logic [2:0]         neg;
   } dv_side_type;

endpackage
`default_nettype wire

>>> design/gnfc_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gnfc_isqrt
// Pipelined integer square root, floor(sqrt(x)) of a 64-bit value, one root
// bit per stage.
// ============================================================================
module gnfc_isqrt (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [63:0] rad,
   output logic      [31:0] root
);

   logic [63:0] rad_ff  [gnfc_pkg::SQRT_STAGES];
   logic [32:0] rem_ff  [gnfc_pkg::SQRT_STAGES];
   logic [31:0] root_ff [gnfc_pkg::SQRT_STAGES];

   for (genvar k = 0; k < gnfc_pkg::SQRT_STAGES; k++) begin : g_stage
      logic [63:0] rad_cur;
      logic [32:0] rem_cur;
      logic [31:0] root_cur;
      logic [34:0] acc;
      logic [34:0] trial;
      logic [63:0] rad_in;
      logic [32:0] rem_in;
      logic [31:0] root_in;

      if (k == 0) begin : g_first
         assign rad_cur  = rad;
         assign rem_cur  = '0;
         assign root_cur = '0;
      end else begin : g_next
         assign rad_cur  = rad_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
      end

      // bring down two radicand bits, try subtracting 4*root+1
      always_comb begin
         acc    = {rem_cur, rad_cur[63:62]};
         trial  = {1'b0, root_cur, 2'b01};
         rad_in = {rad_cur[61:0], 2'b00};
         if (acc >= trial) begin
            rem_in  = 33'(acc - trial);
            root_in = {root_cur[30:0], 1'b1};
         end else begin
            rem_in  = acc[32:0];
            root_in = {root_cur[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root = root_ff[gnfc_pkg::SQRT_STAGES-1];

endmodule
`default_nettype wire

>>> design/gnfc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gnfc_div
// Pipelined restoring divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per stage. The dividend's upper half must be below the divisor.
// ============================================================================
module gnfc_div (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [63:0] dividend,
   input  wire logic [31:0] divisor,
   output logic      [31:0] quotient
);

   logic [31:0] rem_ff [gnfc_pkg::DIV_STAGES];
   logic [31:0] low_ff [gnfc_pkg::DIV_STAGES];
   logic [31:0] quo_ff [gnfc_pkg::DIV_STAGES];
   logic [31:0] dvs_ff [gnfc_pkg::DIV_STAGES];

   for (genvar k = 0; k < gnfc_pkg::DIV_STAGES; k++) begin : g_stage
      logic [31:0] rem_cur;
      logic [31:0] low_cur;
      logic [31:0] quo_cur;
      logic [31:0] dvs_cur;
      logic [32:0] acc;
      logic [31:0] rem_in;
      logic [31:0] quo_in;

      if (k == 0) begin : g_first
         assign rem_cur = dividend[63:32];
         assign low_cur = dividend[31:0];
         assign quo_cur = '0;
         assign dvs_cur = divisor;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign low_cur = low_ff[k-1];
         assign quo_cur = quo_ff[k-1];
         assign dvs_cur = dvs_ff[k-1];
      end

      // shift in one dividend bit, subtract when it fits
      always_comb begin
         acc = {rem_cur, low_cur[31]};
         if (acc >= {1'b0, dvs_cur}) begin
            rem_in = 32'(acc - {1'b0, dvs_cur});
            quo_in = {quo_cur[30:0], 1'b1};
         end else begin
            rem_in = acc[31:0];
            quo_in = {quo_cur[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            low_ff[k] <= {low_cur[30:0], 1'b0};
            quo_ff[k] <= quo_in;
            dvs_ff[k] <= dvs_cur;
         end
      end
   end

   assign quotient = quo_ff[gnfc_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

>>> design/grid_node_friction_collision.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// grid_node_friction_collision
// Coulomb friction collision response of one grid node against a static
// collider, fully pipelined.
// ============================================================================
// Usage:
//   req_* carries one grid node (velocity, signed distance, unit normal) per
//   transfer; rsp_* returns the node's new velocity and its contact kind, one
//   result per node, in order. csr_write_en/csr_write_data set the friction
//   coefficient; write it only while the pipeline is empty.
//   Throughput is one node per cycle when not stalled. A node passes 6 arithmetic
//   stages, 32 square root stages, 2 stages around the tangent scaling
//   multiply, 32 divider stages and the output register from request transfer
//   to response valid. Bit-per-stage square root and divider set the depth.
//   Reset clears all valid bits and the friction coefficient to zero.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and req_ready drops; everything in flight keeps its place, bubbles too.
// ============================================================================
module grid_node_friction_collision (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_vel_x,
   input  wire logic signed [31:0] req_vel_y,
   input  wire logic signed [31:0] req_vel_z,
   input  wire logic signed [31:0] req_signed_distance,
   input  wire logic signed [15:0] req_normal_x,
   input  wire logic signed [15:0] req_normal_y,
   input  wire logic signed [15:0] req_normal_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_out_vel_x,
   output logic signed [31:0]      rsp_out_vel_y,
   output logic signed [31:0]      rsp_out_vel_z,
   output logic        [1:0]       rsp_contact_kind,
   input  wire logic               csr_write_en,
   input  wire logic        [15:0] csr_write_data
);

   localparam int SQ = gnfc_pkg::SQRT_STAGES;
   localparam int DV = gnfc_pkg::DIV_STAGES;

   logic en;
   logic [15:0] fric_ff;

   // stage registers
   logic               s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff;
   logic               s7_v_ff, s8_v_ff;
   logic signed [31:0] s1_vel_ff [3];
   logic signed [15:0] s1_nrm_ff [3];
   logic signed [47:0] s1_prd_ff [3];
   logic               s1_in_ff;
   logic signed [31:0] s2_vel_ff [3];
   logic signed [15:0] s2_nrm_ff [3];
   logic signed [35:0] s2_vn_ff;
   logic               s2_ct_ff;
   logic signed [31:0] s3_vel_ff [3];
   logic signed [51:0] s3_q_ff   [3];
   logic        [51:0] s3_thp_ff;
   logic               s3_ct_ff;
   logic signed [31:0] s4_vel_ff [3];
   logic signed [31:0] s4_t_ff   [3];
   logic        [40:0] s4_thr_ff;
   logic               s4_ct_ff;
   logic        [63:0] s5_sq_ff  [3];
   gnfc_pkg::sq_side_type s5_sb_ff, s6_sb_ff;
   logic        [63:0] s6_sum_ff;
   logic        [SQ-1:0] sq_v_ff;
   gnfc_pkg::sq_side_type sq_sb_ff [SQ];
   logic        [31:0] root;
   logic        [31:0] s7_mag_ff [3];
   logic        [31:0] s7_dif_ff;
   logic        [31:0] s7_nrm_ff;
   gnfc_pkg::dv_side_type s7_sb_ff, s8_sb_ff;
   logic        [63:0] s8_m_ff [3];
   logic        [31:0] s8_nrm_ff;
   logic        [DV-1:0] dv_v_ff;
   gnfc_pkg::dv_side_type dv_sb_ff [DV];
   logic        [31:0] quo [3];

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_vel_ff [3];
   logic        [1:0]  rsp_kind_ff;

   // combinational helpers
   logic signed [31:0] in_vel [3];
   logic signed [15:0] in_nrm [3];
   logic signed [49:0] dot;
   logic signed [50:0] dot_rnd;
   logic        [35:0] avn;
   logic signed [52:0] q_rnd  [3];
   logic signed [39:0] t_wide [3];
   logic signed [31:0] t_sat  [3];
   logic        [52:0] thr_rnd;
   gnfc_pkg::sq_side_type sq_last;
   gnfc_pkg::dv_side_type s7_sb_in;
   logic signed [31:0] res_in [3];
   logic        [1:0]  kind_in;
   gnfc_pkg::dv_side_type dv_last;

   // whole pipeline advances unless a finished result is held
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // friction coefficient register
   always_ff @(posedge clock) begin
      if (reset) begin
         fric_ff <= '0;
      end else if (csr_write_en) begin
         fric_ff <= csr_write_data;
      end
   end

   assign in_vel[0] = req_vel_x;
   assign in_vel[1] = req_vel_y;
   assign in_vel[2] = req_vel_z;
   assign in_nrm[0] = req_normal_x;
   assign in_nrm[1] = req_normal_y;
   assign in_nrm[2] = req_normal_z;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         sq_v_ff <= '0;
         s7_v_ff <= 1'b0;
         s8_v_ff <= 1'b0;
         dv_v_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
         sq_v_ff <= {sq_v_ff[SQ-2:0], s6_v_ff};
         s7_v_ff <= sq_v_ff[SQ-1];
         s8_v_ff <= s7_v_ff;
         dv_v_ff <= {dv_v_ff[DV-2:0], s8_v_ff};
         rsp_valid_ff <= dv_v_ff[DV-1];
      end
   end

   // stage 1: velocity times normal products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s1_vel_ff[i] <= in_vel[i];
            s1_nrm_ff[i] <= in_nrm[i];
            s1_prd_ff[i] <= 48'(in_vel[i] * in_nrm[i]);
         end
         s1_in_ff <= req_signed_distance[31] || (req_signed_distance == '0);
      end
   end

   // stage 2: dot product, contact test, rounded normal speed
   always_comb begin
      dot = 50'(s1_prd_ff[0]) + 50'(s1_prd_ff[1]) + 50'(s1_prd_ff[2]);
      dot_rnd = 51'(dot) + 51'sd8192;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_vel_ff <= s1_vel_ff;
         s2_nrm_ff <= s1_nrm_ff;
         s2_vn_ff  <= dot_rnd[49:14];
         s2_ct_ff  <= s1_in_ff && dot[49];
      end
   end

   // stage 3: normal component products and friction threshold product
   assign avn = s2_vn_ff[35] ? 36'(-s2_vn_ff) : s2_vn_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s3_vel_ff <= s2_vel_ff;
         for (int i = 0; i < 3; i++) begin
            s3_q_ff[i] <= 52'(s2_vn_ff * s2_nrm_ff[i]);
         end
         s3_thp_ff <= 52'(fric_ff * avn);
         s3_ct_ff  <= s2_ct_ff;
      end
   end

   // stage 4: tangential velocity with saturation, rounded threshold
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q_rnd[i]  = 53'(s3_q_ff[i]) + 53'sd8192;
         t_wide[i] = 40'(s3_vel_ff[i]) - 40'($signed(q_rnd[i][52:14]));
         if (t_wide[i] > 40'sd2147483647) begin
            t_sat[i] = 32'sh7FFFFFFF;
         end else if (t_wide[i] < -40'sd2147483648) begin
            t_sat[i] = 32'sh80000000;
         end else begin
            t_sat[i] = t_wide[i][31:0];
         end
      end
      thr_rnd = 53'(s3_thp_ff) + 53'd2048;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_vel_ff <= s3_vel_ff;
         s4_t_ff   <= t_sat;
         s4_thr_ff <= thr_rnd[52:12];
         s4_ct_ff  <= s3_ct_ff;
      end
   end

   // stage 5: squares of the tangential components
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s5_sq_ff[i] <= 64'(s4_t_ff[i] * s4_t_ff[i]);
         end
         s5_sb_ff.vel_x   <= s4_vel_ff[0];
         s5_sb_ff.vel_y   <= s4_vel_ff[1];
         s5_sb_ff.vel_z   <= s4_vel_ff[2];
         s5_sb_ff.tan_x   <= s4_t_ff[0];
         s5_sb_ff.tan_y   <= s4_t_ff[1];
         s5_sb_ff.tan_z   <= s4_t_ff[2];
         s5_sb_ff.thr     <= s4_thr_ff;
         s5_sb_ff.contact <= s4_ct_ff;
      end
   end

   // stage 6: squared tangential speed
   always_ff @(posedge clock) begin
      if (en) begin
         s6_sum_ff <= s5_sq_ff[0] + s5_sq_ff[1] + s5_sq_ff[2];
         s6_sb_ff  <= s5_sb_ff;
      end
   end

   gnfc_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .rad   (s6_sum_ff),
      .root  (root)
   );

   // side data beside the square root
   always_ff @(posedge clock) begin
      if (en) begin
         sq_sb_ff[0] <= s6_sb_ff;
         for (int k = 1; k < SQ; k++) begin
            sq_sb_ff[k] <= sq_sb_ff[k-1];
         end
      end
   end

   // stage 7: stick test, slide factor, tangent magnitudes
   always_comb begin
      sq_last        = sq_sb_ff[SQ-1];
      s7_sb_in.vel_x   = sq_last.vel_x;
      s7_sb_in.vel_y   = sq_last.vel_y;
      s7_sb_in.vel_z   = sq_last.vel_z;
      s7_sb_in.contact = sq_last.contact;
      s7_sb_in.stuck   = {9'd0, root} < sq_last.thr;
      s7_sb_in.nzero   = (root == '0);
      s7_sb_in.neg     = {sq_last.tan_z[31], sq_last.tan_y[31], sq_last.tan_x[31]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_sb_ff     <= s7_sb_in;
         s7_dif_ff    <= root - sq_last.thr[31:0];
         s7_nrm_ff    <= root;
         s7_mag_ff[0] <= sq_last.tan_x[31] ? 32'(-sq_last.tan_x) : sq_last.tan_x;
         s7_mag_ff[1] <= sq_last.tan_y[31] ? 32'(-sq_last.tan_y) : sq_last.tan_y;
         s7_mag_ff[2] <= sq_last.tan_z[31] ? 32'(-sq_last.tan_z) : sq_last.tan_z;
      end
   end

   // stage 8: scale tangent magnitudes before the divide
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s8_m_ff[i] <= 64'(s7_mag_ff[i] * s7_dif_ff);
         end
         s8_nrm_ff <= s7_nrm_ff;
         s8_sb_ff  <= s7_sb_ff;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_div
      gnfc_div u_div (
         .clock    (clock),
         .en       (en),
         .dividend (s8_m_ff[i]),
         .divisor  (s8_nrm_ff),
         .quotient (quo[i])
      );
   end

   // side data beside the dividers
   always_ff @(posedge clock) begin
      if (en) begin
         dv_sb_ff[0] <= s8_sb_ff;
         for (int k = 1; k < DV; k++) begin
            dv_sb_ff[k] <= dv_sb_ff[k-1];
         end
      end
   end

   // output select
   always_comb begin
      dv_last = dv_sb_ff[DV-1];
      if (!dv_last.contact) begin
         res_in[0] = dv_last.vel_x;
         res_in[1] = dv_last.vel_y;
         res_in[2] = dv_last.vel_z;
         kind_in   = gnfc_pkg::KIND_PASS;
      end else if (dv_last.stuck) begin
         res_in    = '{default: '0};
         kind_in   = gnfc_pkg::KIND_STUCK;
      end else begin
         for (int i = 0; i < 3; i++) begin
            if (dv_last.nzero) begin
               res_in[i] = '0;
            end else if (dv_last.neg[i]) begin
               res_in[i] = 32'(-quo[i]);
            end else begin
               res_in[i] = quo[i];
            end
         end
         kind_in = gnfc_pkg::KIND_SLIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_vel_ff  <= res_in;
         rsp_kind_ff <= kind_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_vel_x    = rsp_vel_ff[0];
   assign rsp_out_vel_y    = rsp_vel_ff[1];
   assign rsp_out_vel_z    = rsp_vel_ff[2];
   assign rsp_contact_kind = rsp_kind_ff;

endmodule
`default_nettype wire
